// ===== rtl/tls_pkg.sv =====
`default_nettype none

package tls_pkg;

    // Field widths
    localparam int unsigned LVL_W     = 11;   // fill level 0..2000
    localparam int unsigned OUT_LVL_W = 12;   // output level, room for the fault code
    localparam int unsigned SPD_W     = 9;    // fill speed
    localparam int unsigned DIST_W    = 16;   // sensor distance
    localparam int unsigned TIME_W    = 32;   // millisecond time base

    // Level arithmetic
    localparam logic [LVL_W-1:0]     FULL_LEVEL  = 11'd2000;
    localparam logic [DIST_W-1:0]    ZERO_OFFSET = 16'd210;
    localparam logic [OUT_LVL_W-1:0] FAULT_LEVEL = 12'd3000;
    localparam logic [SPD_W-1:0]     SPEED_MAX   = 9'd511;
    localparam int unsigned          MS_PER_S    = 1000;

    // Frame start byte
    localparam logic [7:0] START_MARK = 8'hFF;

    // Beat operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register reset values
    localparam logic [DIST_W-1:0] MIN_DIST_RST = 16'd220;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 16'd2000;
    localparam logic [15:0]       WIRE_TMO_RST = 16'd1000;

    // Register map
    typedef enum logic [1:0] {
        REG_MIN_DIST = 2'd0,
        REG_MAX_DIST = 2'd1,
        REG_WIRE_TMO = 2'd2
    } t_reg_idx;

    // Input beat
    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [OUT_LVL_W-1:0] level;
        logic [SPD_W-1:0]     fill_speed;
        logic                 sensor_fault;
        logic                 wire_fault;
    } t_out_beat;

    // Frame stage to window stage
    typedef struct packed {
        logic              vld;
        logic              acc;          // reading within range
        logic [LVL_W-1:0]  sample;
        logic              sensor_fault;
        logic              wire_fault;
        logic [TIME_W-1:0] ts;
    } t_s1_beat;

    // Window stage to speed stage
    typedef struct packed {
        logic                 vld;
        logic                 acc;
        logic [OUT_LVL_W-1:0] level;
        logic                 sensor_fault;
        logic                 wire_fault;
        logic [TIME_W-1:0]    ts;
    } t_s2_beat;

endpackage

`default_nettype wire

// ===== rtl/tls_frame_stage.sv =====
`default_nettype none

module tls_frame_stage #(
    parameter int unsigned EMPTY_SPAN = 1300
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_take,
    input  tls_pkg::t_in_beat  i_beat,
    input  logic               i_load,
    output tls_pkg::t_s1_beat  o_beat
);
    import tls_pkg::*;

    // Distance above the offset is cut to X_W bits for the multiplier; at or above EMPTY_SPAN the product is unused
    localparam int unsigned X_W    = $clog2(EMPTY_SPAN);
    localparam int unsigned LVL_S  = 2 * X_W;
    localparam longint unsigned LVL_M =
        (longint'(FULL_LEVEL) * (64'd1 << LVL_S) + EMPTY_SPAN - 1) / EMPTY_SPAN;
    localparam int unsigned PROD_W = LVL_S + LVL_W + 1;

    typedef enum logic [1:0] {
        POS_START,
        POS_HIGH,
        POS_LOW,
        POS_SUM
    } t_pos;

    t_pos              r_pos, n_pos;
    logic [7:0]        r_hi, n_hi;
    logic [7:0]        r_lo, n_lo;
    logic [DIST_W-1:0] r_min, r_max;
    logic [15:0]       r_tmo;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_last, n_last;
    logic              r_sflag, n_sflag;
    logic              r_wflag, n_wflag;
    t_s1_beat          r_s1, n_s1;

    logic              done;
    logic              fire;
    logic [DIST_W-1:0] distance;
    logic [TIME_W-1:0] elapsed;
    logic              in_range;
    logic [DIST_W-1:0] xd;
    logic              over;
    logic [PROD_W-1:0] prod;
    logic [LVL_W-1:0]  e_lvl;
    logic [LVL_W-1:0]  sample;

    // Frame parser and millisecond timer
    always_comb begin
        n_pos    = r_pos;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_now    = r_now;
        n_last   = r_last;
        n_sflag  = r_sflag;
        n_wflag  = r_wflag;
        done     = 1'b0;
        fire     = 1'b0;
        distance = '0;
        elapsed  = '0;
        if (i_take && i_beat.op == OP_TICK) begin
            n_now   = r_now + 1'b1;
            elapsed = n_now - r_last;
            if (!r_wflag && elapsed >= {16'd0, r_tmo}) begin
                fire    = 1'b1;
                n_wflag = 1'b1;
            end
        end else if (i_take) begin
            case (r_pos)
                POS_START: begin
                    if (i_beat.rx_byte == START_MARK) begin
                        n_pos = POS_HIGH;
                    end else begin
                        done = 1'b1;      // stray byte reads as distance zero
                    end
                end
                POS_HIGH: begin
                    n_hi  = i_beat.rx_byte;
                    n_pos = POS_LOW;
                end
                POS_LOW: begin
                    n_lo  = i_beat.rx_byte;
                    n_pos = POS_SUM;
                end
                POS_SUM: begin
                    n_pos = POS_START;
                    done  = 1'b1;
                    // checksum is the unwrapped 9-bit sum
                    if (({1'b0, r_hi} + {1'b0, r_lo}) == {1'b0, i_beat.rx_byte}) begin
                        distance = {r_hi, r_lo};
                    end
                end
                default: n_pos = POS_START;
            endcase
        end

        in_range = (distance >= r_min) && (distance <= r_max);
        if (done) begin
            n_sflag = !in_range;
            n_wflag = 1'b0;
            n_last  = r_now;
        end
    end

    // Distance to fill level: scaled by 2000/EMPTY_SPAN through a reciprocal
    always_comb begin
        xd     = (distance > ZERO_OFFSET) ? (distance - ZERO_OFFSET) : '0;
        over   = xd >= DIST_W'(EMPTY_SPAN);
        prod   = PROD_W'(xd[X_W-1:0]) * PROD_W'(LVL_M);
        e_lvl  = prod[LVL_S +: LVL_W];
        sample = over ? '0 : (FULL_LEVEL - e_lvl);
    end

    // Stage beat
    always_comb begin
        n_s1.vld          = done || fire;
        n_s1.acc          = done && in_range;
        n_s1.sample       = sample;
        n_s1.sensor_fault = n_sflag;
        n_s1.wire_fault   = n_wflag;
        n_s1.ts           = r_now;
    end

    // Parser state, timers, registers and stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_START;
            r_hi    <= '0;
            r_lo    <= '0;
            r_min   <= MIN_DIST_RST;
            r_max   <= MAX_DIST_RST;
            r_tmo   <= WIRE_TMO_RST;
            r_now   <= '0;
            r_last  <= '0;
            r_sflag <= 1'b0;
            r_wflag <= 1'b0;
            r_s1    <= '0;
        end else begin
            r_pos   <= n_pos;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
            r_now   <= n_now;
            r_last  <= n_last;
            r_sflag <= n_sflag;
            r_wflag <= n_wflag;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MIN_DIST: r_min <= i_cfg_data;
                    REG_MAX_DIST: r_max <= i_cfg_data;
                    REG_WIRE_TMO: r_tmo <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_load) begin
                r_s1 <= n_s1;
            end
        end
    end

    assign o_beat = r_s1;

endmodule

`default_nettype wire

// ===== rtl/tls_window_stage.sv =====
`default_nettype none

module tls_window_stage #(
    parameter int unsigned WINDOW = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tls_pkg::t_s1_beat i_beat,
    input  logic              i_load,
    output tls_pkg::t_s2_beat o_beat
);
    import tls_pkg::*;

    localparam int unsigned SUM_W  = $clog2(int'(FULL_LEVEL) * WINDOW + 1);
    localparam int unsigned PTR_W  = $clog2(WINDOW);
    // floor(sum / WINDOW) as an exact multiply by a rounded-up reciprocal
    localparam int unsigned AVG_S  = SUM_W + $clog2(WINDOW);
    localparam longint unsigned AVG_M = ((64'd1 << AVG_S) + WINDOW - 1) / WINDOW;
    localparam int unsigned PROD_W = AVG_S + LVL_W + 1;

    logic [LVL_W-1:0]  mem [WINDOW];
    logic [WINDOW-1:0] r_fill;
    logic [PTR_W-1:0]  r_ptr;
    logic [SUM_W-1:0]  r_sum;
    logic [LVL_W-1:0]  r_old_data;
    logic              r_old_vld;
    t_s2_beat          r_s2, n_s2;

    logic              upd;
    logic [PTR_W-1:0]  n_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic [LVL_W-1:0]  old;
    logic [SUM_W-1:0]  n_sum;
    logic [PROD_W-1:0] prod;
    logic [LVL_W-1:0]  avg;

    // Running sum over the window, oldest sample prefetched
    always_comb begin
        upd    = i_load && i_beat.vld && i_beat.acc;
        n_ptr  = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : (r_ptr + 1'b1);
        rd_ptr = upd ? n_ptr : r_ptr;
        old    = r_old_vld ? r_old_data : '0;
        n_sum  = r_sum - SUM_W'(old) + SUM_W'(i_beat.sample);
        prod   = PROD_W'(n_sum) * PROD_W'(AVG_M);
        avg    = prod[AVG_S +: LVL_W];
    end

    // Stage beat
    always_comb begin
        n_s2.vld          = i_beat.vld;
        n_s2.acc          = i_beat.acc;
        n_s2.level        = i_beat.acc ? {1'b0, avg} : FAULT_LEVEL;
        n_s2.sensor_fault = i_beat.sensor_fault;
        n_s2.wire_fault   = i_beat.wire_fault;
        n_s2.ts           = i_beat.ts;
    end

    // Sample store: write the newest, read the next oldest
    always_ff @(posedge i_clk) begin
        if (upd) begin
            mem[r_ptr] <= i_beat.sample;
        end
        r_old_data <= mem[rd_ptr];
    end

    // Fill bits, pointer, sum and stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_ptr     <= '0;
            r_sum     <= '0;
            r_old_vld <= 1'b0;
            r_s2      <= '0;
        end else begin
            if (upd) begin
                r_fill[r_ptr] <= 1'b1;
                r_ptr         <= n_ptr;
                r_sum         <= n_sum;
            end
            r_old_vld <= r_fill[rd_ptr];
            if (i_load) begin
                r_s2 <= n_s2;
            end
        end
    end

    assign o_beat = r_s2;

endmodule

`default_nettype wire

// ===== rtl/tls_speed_stage.sv =====
`default_nettype none

module tls_speed_stage #(
    parameter int unsigned SPEED_INTERVAL_MS = 5000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tls_pkg::t_s2_beat  i_beat,
    input  logic               i_load,
    output logic               o_valid,
    output tls_pkg::t_out_beat o_beat
);
    import tls_pkg::*;

    // rise * 1000 / interval as an exact reciprocal multiply
    localparam int unsigned SPD_S  = LVL_W + $clog2(SPEED_INTERVAL_MS);
    localparam longint unsigned SPD_M =
        (longint'(MS_PER_S) * (64'd1 << SPD_S) + SPEED_INTERVAL_MS - 1) / SPEED_INTERVAL_MS;
    localparam int unsigned PROD_W = SPD_S + LVL_W + 1;

    logic [LVL_W-1:0]  r_prev;
    logic [TIME_W-1:0] r_last_spd;
    logic [SPD_W-1:0]  r_speed;
    logic              r_out_vld;
    t_out_beat         r_out, n_out;

    logic [LVL_W-1:0]  lvl;
    logic [LVL_W-1:0]  diff;
    logic [TIME_W-1:0] elapsed;
    logic              rise;
    logic [PROD_W-1:0] prod;
    logic [LVL_W-1:0]  v;
    logic [SPD_W-1:0]  v_sat;

    // Speed update on a rise once the interval has run
    always_comb begin
        lvl     = i_beat.level[LVL_W-1:0];
        diff    = lvl - r_prev;
        elapsed = i_beat.ts - r_last_spd;
        rise    = i_beat.acc && (lvl > r_prev) &&
                  (elapsed >= TIME_W'(SPEED_INTERVAL_MS));
        prod    = PROD_W'(diff) * PROD_W'(SPD_M);
        v       = prod[SPD_S +: LVL_W];
        v_sat   = (v > LVL_W'(SPEED_MAX)) ? SPEED_MAX : v[SPD_W-1:0];
    end

    // Result beat
    always_comb begin
        n_out.level        = i_beat.level;
        n_out.fill_speed   = rise ? v_sat : r_speed;
        n_out.sensor_fault = i_beat.sensor_fault;
        n_out.wire_fault   = i_beat.wire_fault;
    end

    // Speed state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_last_spd <= '0;
            r_speed    <= '0;
            r_out_vld  <= 1'b0;
        end else if (i_load) begin
            r_out_vld <= i_beat.vld;
            if (i_beat.vld && rise) begin
                r_prev     <= lvl;
                r_last_spd <= i_beat.ts;
                r_speed    <= v_sat;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_beat  = r_out;

endmodule

`default_nettype wire

// ===== rtl/tank_level_sensor_filter.sv =====
// Tank level sensor filter.
// Input channel (i_valid / o_stall / i_data): each beat is either a received
// sensor byte or a one-millisecond tick. Bytes are parsed into distance frames;
// each finished reading, and each wire timeout, gives one result beat.
// Result channel (o_valid / i_stall / o_data): averaged level, fill speed and
// the two fault flags.
// Configuration channel (i_cfg_valid / o_cfg_ready): distance limits and wire
// timeout; ready is always high, writes are expected while the block is idle.
// Throughput: one input beat per cycle while o_stall is low. A result passes
// through the frame stage, window stage and speed stage with the output
// register; the window sum and level are updated in the same cycle.
// When the receiver stalls, the result holds and the stages behind it keep
// filling; o_stall rises only once all three stage registers hold results.
// Reset (synchronous, active low) empties the pipeline, clears the sample
// window, timers, faults and speed, and loads the register defaults.
`default_nettype none

module tank_level_sensor_filter #(
    parameter int unsigned WINDOW            = 30,
    parameter int unsigned EMPTY_SPAN        = 1300,
    parameter int unsigned SPEED_INTERVAL_MS = 5000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tls_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output tls_pkg::t_out_beat o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import tls_pkg::*;

    t_s1_beat s1;
    t_s2_beat s2;
    logic     out_free;
    logic     s2_free;
    logic     s1_free;
    logic     accept;

    // Stage advance: each register moves when the one after it has room
    assign out_free    = !o_valid || !i_stall;
    assign s2_free     = !s2.vld || out_free;
    assign s1_free     = !s1.vld || s2_free;
    assign accept      = i_valid && s1_free;
    assign o_stall     = !s1_free;
    assign o_cfg_ready = 1'b1;

    tls_frame_stage #(
        .EMPTY_SPAN (EMPTY_SPAN)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (accept),
        .i_beat      (i_data),
        .i_load      (s1_free),
        .o_beat      (s1)
    );

    tls_window_stage #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (s1),
        .i_load  (s2_free),
        .o_beat  (s2)
    );

    tls_speed_stage #(
        .SPEED_INTERVAL_MS (SPEED_INTERVAL_MS)
    ) u_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (s2),
        .i_load  (out_free),
        .o_valid (o_valid),
        .o_beat  (o_data)
    );

endmodule

`default_nettype wire

// ===== rtl/tls_checker.sv =====
`default_nettype none

module tls_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input tls_pkg::t_out_beat o_data
);
    import tls_pkg::*;

    // A stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    // Wire fault always carries the fault level
    a_wire_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.wire_fault |-> o_data.level == FAULT_LEVEL)
        else $error("wire fault without fault level");

    // Sensor fault always carries the fault level
    a_sensor_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.sensor_fault |-> o_data.level == FAULT_LEVEL)
        else $error("sensor fault without fault level");

    // A healthy average never exceeds full
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.sensor_fault && !o_data.wire_fault
            |-> o_data.level <= OUT_LVL_W'(FULL_LEVEL))
        else $error("average level above full");

endmodule

bind tank_level_sensor_filter tls_checker u_tls_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire
